/* hw/rtl/lkrm_pkg.sv */
// shared types and constants for the link keepalive / reconnect manager
package lkrm_pkg;

  localparam int TICKS_PER_SECOND = 1000;
  localparam int ELAPSED_WIDTH    = 20;

  typedef logic [ELAPSED_WIDTH-1:0] elapsed_t;

  typedef struct packed {
    elapsed_t count;
    logic     expired;
  } tmr_res_t;

  typedef enum logic [2:0] {
    KIND_TICK       = 3'd0,
    KIND_CONNECT    = 3'd1,
    KIND_DISCONNECT = 3'd2,
    KIND_ACK        = 3'd3,
    KIND_NAK        = 3'd4,
    KIND_POLL       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    MODE_DISABLED   = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2
  } mode_t;

  localparam logic [1:0] REG_POLL_INTERVAL  = 2'd0;
  localparam logic [1:0] REG_INACT_TIMEOUT  = 2'd1;
  localparam logic [1:0] REG_MAX_BACKOFF    = 2'd2;
  localparam logic [1:0] REG_INITIAL_RETRY  = 2'd3;

  localparam logic [7:0] POLL_INTERVAL_RST = 8'd10;
  localparam logic [7:0] INACT_TIMEOUT_RST = 8'd60;
  localparam logic [7:0] MAX_BACKOFF_RST   = 8'd60;
  localparam logic [7:0] INITIAL_RETRY_RST = 8'd1;
  localparam logic [7:0] RETRY_TIMEOUT_RST = 8'd1;

  localparam logic [2:0] TRY_MAX = 3'd7;

endpackage

/* hw/rtl/lkrm_timer.sv */
// saturating elapsed-count advance and expiry compare for one timer
module lkrm_timer (
  input  logic               running,
  input  lkrm_pkg::elapsed_t count,
  input  logic [15:0]        ticks,
  input  logic [7:0]         secs,
  output lkrm_pkg::tmr_res_t res
);

  logic [lkrm_pkg::ELAPSED_WIDTH:0]   sum;
  lkrm_pkg::elapsed_t                 adv;
  lkrm_pkg::elapsed_t                 limit;

  assign sum   = {1'b0, count} + (lkrm_pkg::ELAPSED_WIDTH + 1)'(ticks);
  assign adv   = !running ? count :
                 (sum[lkrm_pkg::ELAPSED_WIDTH] ? '1 : sum[lkrm_pkg::ELAPSED_WIDTH-1:0]);
  assign limit = lkrm_pkg::ELAPSED_WIDTH'(32'(secs) * 32'(lkrm_pkg::TICKS_PER_SECOND));

  assign res.count   = adv;
  assign res.expired = running && (secs != 8'd0) && (adv >= limit);

endmodule

/* hw/rtl/link_keepalive_reconnect_manager.sv */
// link keepalive / reconnect manager top level with retry backoff
// a result word is offered from the output register after its input word has passed the input register
// throughput: one word per cycle while the output is not stalled, set by the single registered update stage
// an input register and an output register split the two channels
// reset (synchronous, rst_n low) restores register defaults, disabled state,
// stopped timers, retry timeout 1 and try count 0
module link_keepalive_reconnect_manager (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [15:0] in_elapsed_ms,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_send_connect,
  output logic        out_send_poll,
  output logic        out_send_unlink,
  output logic [1:0]  out_link_state,
  output logic [7:0]  out_retry_interval_s
);

  logic [7:0] poll_ivl_r, inact_to_r, max_bo_r, init_retry_r;

  logic                s1_valid_r;
  logic [2:0]          s1_kind_r;
  logic [15:0]         s1_ms_r;

  lkrm_pkg::mode_t     mode_r, mode_nxt;
  logic                inact_run_r, inact_run_nxt;
  lkrm_pkg::elapsed_t  inact_cnt_r, inact_cnt_nxt;
  logic                poll_run_r, poll_run_nxt;
  lkrm_pkg::elapsed_t  poll_cnt_r, poll_cnt_nxt;
  logic                retry_run_r, retry_run_nxt;
  lkrm_pkg::elapsed_t  retry_cnt_r, retry_cnt_nxt;
  logic [7:0]          retry_to_r, retry_to_nxt;
  logic [2:0]          try_r, try_nxt;

  logic                out_valid_r;
  logic                send_conn_r, send_conn_nxt;
  logic                send_poll_r, send_poll_nxt;
  logic                send_unlink_r, send_unlink_nxt;
  logic [1:0]          link_state_r;
  logic [7:0]          retry_ivl_r;

  logic                out_ready;
  logic                s1_go;
  logic                in_take;
  lkrm_pkg::tmr_res_t  inact_res, poll_res, retry_res;
  logic [7:0]          pow2;
  logic [7:0]          backoff;

  assign out_ready = !out_valid_r || !out_stall;
  assign s1_go     = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  lkrm_timer u_inact_tmr (
    .running (inact_run_r),
    .count   (inact_cnt_r),
    .ticks   (s1_ms_r),
    .secs    (inact_to_r),
    .res     (inact_res)
  );

  lkrm_timer u_poll_tmr (
    .running (poll_run_r),
    .count   (poll_cnt_r),
    .ticks   (s1_ms_r),
    .secs    (poll_ivl_r),
    .res     (poll_res)
  );

  lkrm_timer u_retry_tmr (
    .running (retry_run_r),
    .count   (retry_cnt_r),
    .ticks   (s1_ms_r),
    .secs    (retry_to_r),
    .res     (retry_res)
  );

  assign pow2    = 8'd1 << try_r;
  assign backoff = (pow2 > max_bo_r) ? max_bo_r : pow2;

  always_comb begin
    mode_nxt        = mode_r;
    inact_run_nxt   = inact_run_r;
    inact_cnt_nxt   = inact_cnt_r;
    poll_run_nxt    = poll_run_r;
    poll_cnt_nxt    = poll_cnt_r;
    retry_run_nxt   = retry_run_r;
    retry_cnt_nxt   = retry_cnt_r;
    retry_to_nxt    = retry_to_r;
    try_nxt         = try_r;
    send_conn_nxt   = 1'b0;
    send_poll_nxt   = 1'b0;
    send_unlink_nxt = 1'b0;
    case (s1_kind_r)
      lkrm_pkg::KIND_TICK: begin
        inact_cnt_nxt = inact_res.count;
        poll_cnt_nxt  = poll_res.count;
        retry_cnt_nxt = retry_res.count;
        if (inact_res.expired) begin
          inact_run_nxt = 1'b0;
          poll_run_nxt  = 1'b0;
          retry_to_nxt  = init_retry_r;
          retry_run_nxt = 1'b1;
          retry_cnt_nxt = '0;
          try_nxt       = 3'd1;
          mode_nxt      = lkrm_pkg::MODE_CONNECTING;
        end else begin
          if (retry_res.expired) begin
            send_conn_nxt = 1'b1;
            retry_to_nxt  = backoff;
            retry_cnt_nxt = '0;
            if (try_r != lkrm_pkg::TRY_MAX) begin
              try_nxt = try_r + 3'd1;
            end
          end
          if (poll_res.expired) begin
            send_poll_nxt = 1'b1;
            poll_cnt_nxt  = '0;
          end
        end
      end
      lkrm_pkg::KIND_CONNECT: begin
        send_conn_nxt = 1'b1;
        retry_to_nxt  = init_retry_r;
        retry_run_nxt = 1'b1;
        retry_cnt_nxt = '0;
        try_nxt       = 3'd1;
        mode_nxt      = lkrm_pkg::MODE_CONNECTING;
      end
      lkrm_pkg::KIND_DISCONNECT: begin
        send_unlink_nxt = 1'b1;
        inact_run_nxt   = 1'b0;
        poll_run_nxt    = 1'b0;
        mode_nxt        = lkrm_pkg::MODE_DISABLED;
      end
      lkrm_pkg::KIND_ACK: begin
        if (mode_r == lkrm_pkg::MODE_CONNECTING) begin
          inact_run_nxt = 1'b1;
          inact_cnt_nxt = '0;
          poll_run_nxt  = 1'b1;
          poll_cnt_nxt  = '0;
          retry_run_nxt = 1'b0;
          mode_nxt      = lkrm_pkg::MODE_CONNECTED;
        end
      end
      lkrm_pkg::KIND_NAK: begin
        if (mode_r == lkrm_pkg::MODE_CONNECTING) begin
          retry_run_nxt = 1'b0;
          mode_nxt      = lkrm_pkg::MODE_DISABLED;
        end
      end
      lkrm_pkg::KIND_POLL: begin
        inact_cnt_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_ivl_r   <= lkrm_pkg::POLL_INTERVAL_RST;
      inact_to_r   <= lkrm_pkg::INACT_TIMEOUT_RST;
      max_bo_r     <= lkrm_pkg::MAX_BACKOFF_RST;
      init_retry_r <= lkrm_pkg::INITIAL_RETRY_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      mode_r       <= lkrm_pkg::MODE_DISABLED;
      inact_run_r  <= 1'b0;
      inact_cnt_r  <= '0;
      poll_run_r   <= 1'b0;
      poll_cnt_r   <= '0;
      retry_run_r  <= 1'b0;
      retry_cnt_r  <= '0;
      retry_to_r   <= lkrm_pkg::RETRY_TIMEOUT_RST;
      try_r        <= 3'd0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          lkrm_pkg::REG_POLL_INTERVAL: poll_ivl_r   <= cfg_wdata;
          lkrm_pkg::REG_INACT_TIMEOUT: inact_to_r   <= cfg_wdata;
          lkrm_pkg::REG_MAX_BACKOFF:   max_bo_r     <= cfg_wdata;
          lkrm_pkg::REG_INITIAL_RETRY: init_retry_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (in_take) begin
        s1_kind_r <= in_kind;
        s1_ms_r   <= in_elapsed_ms;
      end
      if (out_ready) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_go) begin
        mode_r        <= mode_nxt;
        inact_run_r   <= inact_run_nxt;
        inact_cnt_r   <= inact_cnt_nxt;
        poll_run_r    <= poll_run_nxt;
        poll_cnt_r    <= poll_cnt_nxt;
        retry_run_r   <= retry_run_nxt;
        retry_cnt_r   <= retry_cnt_nxt;
        retry_to_r    <= retry_to_nxt;
        try_r         <= try_nxt;
        send_conn_r   <= send_conn_nxt;
        send_poll_r   <= send_poll_nxt;
        send_unlink_r <= send_unlink_nxt;
        link_state_r  <= mode_nxt;
        retry_ivl_r   <= retry_to_nxt;
      end
    end
  end

  assign out_valid            = out_valid_r;
  assign out_send_connect     = send_conn_r;
  assign out_send_poll        = send_poll_r;
  assign out_send_unlink      = send_unlink_r;
  assign out_link_state       = link_state_r;
  assign out_retry_interval_s = retry_ivl_r;

  // an unlink word never carries other send requests and reports disabled
  a_unlink_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && send_unlink_r) |->
      (!send_conn_r && !send_poll_r && link_state_r == lkrm_pkg::MODE_DISABLED))
    else $error("unlink word with other requests or wrong state");

  // retry timer only runs after an attempt has set the try count
  a_retry_try: assert property (@(posedge clk) disable iff (!rst_n)
    retry_run_r |-> (try_r != 3'd0))
    else $error("retry timer running with zero try count");

  // a staged word moves to the output register when it is free
  a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("staged word lost on its way to the output");

  // stall is raised only while a word waits in the input register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked word");

endmodule

/* dv/lkrm_tb_pkg.sv */
// result word type and scoreboard for the link keepalive / reconnect manager testbench
package lkrm_tb_pkg;

  typedef struct packed {
    logic            send_connect;
    logic            send_poll;
    logic            send_unlink;
    lkrm_pkg::mode_t link_state;
    logic [7:0]      retry_interval_s;
  } link_word_t;

  class link_scoreboard;

    logic [7:0] poll_s;
    logic [7:0] inact_s;
    logic [7:0] backoff_cap_s;
    logic [7:0] init_retry_s;

    lkrm_pkg::mode_t    mode;
    bit                 inact_run;
    bit                 poll_run;
    bit                 retry_run;
    lkrm_pkg::elapsed_t inact_cnt;
    lkrm_pkg::elapsed_t poll_cnt;
    lkrm_pkg::elapsed_t retry_cnt;
    logic [7:0]         retry_s;
    logic [2:0]         tries;

    link_word_t link_words_due[$];
    int         errors;
    int         events_noted;
    int         words_checked;

    function new();
      poll_s        = lkrm_pkg::POLL_INTERVAL_RST;
      inact_s       = lkrm_pkg::INACT_TIMEOUT_RST;
      backoff_cap_s = lkrm_pkg::MAX_BACKOFF_RST;
      init_retry_s  = lkrm_pkg::INITIAL_RETRY_RST;
      mode          = lkrm_pkg::MODE_DISABLED;
      inact_run     = 1'b0;
      poll_run      = 1'b0;
      retry_run     = 1'b0;
      inact_cnt     = '0;
      poll_cnt      = '0;
      retry_cnt     = '0;
      retry_s       = lkrm_pkg::RETRY_TIMEOUT_RST;
      tries         = '0;
      errors        = 0;
      events_noted  = 0;
      words_checked = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [7:0] value);
      case (idx)
        lkrm_pkg::REG_POLL_INTERVAL: poll_s        = value;
        lkrm_pkg::REG_INACT_TIMEOUT: inact_s       = value;
        lkrm_pkg::REG_MAX_BACKOFF:   backoff_cap_s = value;
        lkrm_pkg::REG_INITIAL_RETRY: init_retry_s  = value;
        default: ;
      endcase
    endfunction

    function lkrm_pkg::elapsed_t advance(bit run, lkrm_pkg::elapsed_t cnt, logic [15:0] ms);
      logic [lkrm_pkg::ELAPSED_WIDTH:0] sum;
      if (!run) return cnt;
      sum = {1'b0, cnt} + ms;
      if (sum[lkrm_pkg::ELAPSED_WIDTH]) return '1;
      return sum[lkrm_pkg::ELAPSED_WIDTH-1:0];
    endfunction

    function bit timer_done(bit run, lkrm_pkg::elapsed_t cnt, logic [7:0] secs);
      return run && secs != 0 &&
             (int'(cnt) >= int'(secs) * lkrm_pkg::TICKS_PER_SECOND);
    endfunction

    function logic [7:0] backoff_step();
      int t;
      t = 1 << tries;
      if (tries < lkrm_pkg::TRY_MAX) tries = tries + 3'd1;
      if (t > int'(backoff_cap_s)) t = int'(backoff_cap_s);
      return 8'(t);
    endfunction

    function void restart_attempt();
      retry_s   = init_retry_s;
      retry_run = 1'b1;
      retry_cnt = '0;
      tries     = 3'd1;
      mode      = lkrm_pkg::MODE_CONNECTING;
    endfunction

    function void predict_event(logic [2:0] kind, logic [15:0] ms);
      link_word_t w;
      w = '0;
      case (lkrm_pkg::kind_t'(kind))
        lkrm_pkg::KIND_TICK: begin
          inact_cnt = advance(inact_run, inact_cnt, ms);
          poll_cnt  = advance(poll_run, poll_cnt, ms);
          retry_cnt = advance(retry_run, retry_cnt, ms);
          if (timer_done(inact_run, inact_cnt, inact_s)) begin
            inact_run = 1'b0;
            poll_run  = 1'b0;
            restart_attempt();
          end else begin
            if (timer_done(retry_run, retry_cnt, retry_s)) begin
              w.send_connect = 1'b1;
              retry_s        = backoff_step();
              retry_cnt      = '0;
            end
            if (timer_done(poll_run, poll_cnt, poll_s)) begin
              w.send_poll = 1'b1;
              poll_cnt    = '0;
            end
          end
        end
        lkrm_pkg::KIND_CONNECT: begin
          w.send_connect = 1'b1;
          restart_attempt();
        end
        lkrm_pkg::KIND_DISCONNECT: begin
          w.send_unlink = 1'b1;
          inact_run     = 1'b0;
          poll_run      = 1'b0;
          mode          = lkrm_pkg::MODE_DISABLED;
        end
        lkrm_pkg::KIND_ACK: begin
          if (mode == lkrm_pkg::MODE_CONNECTING) begin
            inact_run = 1'b1;
            inact_cnt = '0;
            poll_run  = 1'b1;
            poll_cnt  = '0;
            retry_run = 1'b0;
            mode      = lkrm_pkg::MODE_CONNECTED;
          end
        end
        lkrm_pkg::KIND_NAK: begin
          if (mode == lkrm_pkg::MODE_CONNECTING) begin
            retry_run = 1'b0;
            mode      = lkrm_pkg::MODE_DISABLED;
          end
        end
        lkrm_pkg::KIND_POLL: inact_cnt = '0;
        default: ;
      endcase
      w.link_state       = mode;
      w.retry_interval_s = retry_s;
      link_words_due.push_back(w);
      events_noted++;
    endfunction

    task report(string msg);
      $display("mismatch at result word %0d: %s", words_checked, msg);
      errors++;
    endtask

    task check_word(link_word_t got);
      link_word_t want;
      if (link_words_due.size() == 0) begin
        report("result word with no event outstanding");
        return;
      end
      want = link_words_due.pop_front();
      words_checked++;
      if (got.send_connect !== want.send_connect)
        report($sformatf("send_connect %0b, want %0b", got.send_connect, want.send_connect));
      if (got.send_poll !== want.send_poll)
        report($sformatf("send_poll %0b, want %0b", got.send_poll, want.send_poll));
      if (got.send_unlink !== want.send_unlink)
        report($sformatf("send_unlink %0b, want %0b", got.send_unlink, want.send_unlink));
      if (got.link_state !== want.link_state)
        report($sformatf("link_state %0d, want %0d", got.link_state, want.link_state));
      if (got.retry_interval_s !== want.retry_interval_s)
        report($sformatf("retry_interval_s %0d, want %0d",
                         got.retry_interval_s, want.retry_interval_s));
    endtask

  endclass

endpackage

/* dv/link_keepalive_reconnect_manager_tb.sv */
// testbench top for the link keepalive / reconnect manager
module link_keepalive_reconnect_manager_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_PER_PHASE = 230;
  localparam int PHASES           = 5;
  localparam int LONG_HOLD        = 80;
  localparam int QUIET_LIMIT      = 3000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  in_kind;
  logic [15:0] in_elapsed_ms;
  logic        out_valid;
  logic        out_stall;
  logic        out_send_connect;
  logic        out_send_poll;
  logic        out_send_unlink;
  logic [1:0]  out_link_state;
  logic [7:0]  out_retry_interval_s;

  lkrm_tb_pkg::link_scoreboard sb = new();
  int idle_mode;
  bit hold_request;
  int settings_used;
  logic [1:0] reg_ids [4] = '{lkrm_pkg::REG_POLL_INTERVAL, lkrm_pkg::REG_INACT_TIMEOUT,
                              lkrm_pkg::REG_MAX_BACKOFF, lkrm_pkg::REG_INITIAL_RETRY};

  link_keepalive_reconnect_manager dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_elapsed_ms       (in_elapsed_ms),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_send_connect    (out_send_connect),
    .out_send_poll       (out_send_poll),
    .out_send_unlink     (out_send_unlink),
    .out_link_state      (out_link_state),
    .out_retry_interval_s(out_retry_interval_s)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin : word_monitor
    lkrm_tb_pkg::link_word_t got;
    if (rst_n && in_valid && !in_stall)
      sb.predict_event(in_kind, in_elapsed_ms);
    if (rst_n && out_valid && !out_stall) begin
      got.send_connect     = out_send_connect;
      got.send_poll        = out_send_poll;
      got.send_unlink      = out_send_unlink;
      got.link_state       = lkrm_pkg::mode_t'(out_link_state);
      got.retry_interval_s = out_retry_interval_s;
      sb.check_word(got);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet = 0;
      else quiet++;
    end
    $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
    $display("link_keepalive_reconnect_manager_tb: errors");
    $finish;
  end

  initial begin : receiver
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
      end
      out_stall <= (idle_mode == 2 && $urandom_range(99) < 61) ||
                   (idle_mode == 3 && $urandom_range(99) < 11);
    end
  end

  task automatic send_event(lkrm_pkg::kind_t kind, logic [15:0] ms);
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_elapsed_ms <= ms;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap();
    int pct;
    pct = (idle_mode == 1) ? 61 : (idle_mode == 3) ? 11 : 0;
    while ($urandom_range(99) < pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic drain_and_configure(logic [7:0] vals [4]);
    in_valid <= 1'b0;
    while (sb.link_words_due.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= reg_ids[i];
      cfg_wdata <= vals[i];
      sb.write_reg(reg_ids[i], vals[i]);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    settings_used++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] random_ms();
    int r;
    r = $urandom_range(99);
    if (r < 40) return 16'($urandom_range(1500));
    if (r < 70) return 16'($urandom_range(15000));
    if (r < 85) return 16'($urandom_range(65535));
    if (r < 95) return 16'hFFFF;
    return 16'h0000;
  endfunction

  function automatic lkrm_pkg::kind_t random_kind();
    int r;
    r = $urandom_range(99);
    if (r < 55) return lkrm_pkg::KIND_TICK;
    if (r < 70) return lkrm_pkg::KIND_POLL;
    if (r < 82) return lkrm_pkg::KIND_ACK;
    if (r < 90) return lkrm_pkg::KIND_CONNECT;
    if (r < 95) return lkrm_pkg::KIND_NAK;
    return lkrm_pkg::KIND_DISCONNECT;
  endfunction

  initial begin : stimulus
    logic [7:0] vals [4];
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = lkrm_pkg::REG_POLL_INTERVAL;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_kind       = lkrm_pkg::KIND_TICK;
    in_elapsed_ms = '0;
    idle_mode     = 0;
    hold_request  = 1'b0;
    settings_used = 1;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // disabled link ignores ack, nak and poll
    send_event(lkrm_pkg::KIND_TICK, 16'd0);
    send_event(lkrm_pkg::KIND_ACK, 16'd0);
    send_event(lkrm_pkg::KIND_NAK, 16'd0);
    send_event(lkrm_pkg::KIND_POLL, 16'd0);
    // connect, retry just short of and at its timeout, then backoff up to the cap
    send_event(lkrm_pkg::KIND_CONNECT, 16'd0);
    send_event(lkrm_pkg::KIND_TICK, 16'd999);
    send_event(lkrm_pkg::KIND_TICK, 16'd1);
    repeat (6) send_event(lkrm_pkg::KIND_TICK, 16'hFFFF);
    // ack connects, a second ack is ignored, poll timer fires
    send_event(lkrm_pkg::KIND_ACK, 16'd0);
    send_event(lkrm_pkg::KIND_ACK, 16'd0);
    send_event(lkrm_pkg::KIND_TICK, 16'd9999);
    send_event(lkrm_pkg::KIND_TICK, 16'd1);
    send_event(lkrm_pkg::KIND_POLL, 16'd0);
    // inactivity timeout forces a reconnect and wins over the poll timer
    send_event(lkrm_pkg::KIND_TICK, 16'hFFFF);
    send_event(lkrm_pkg::KIND_NAK, 16'd0);
    // retry timer keeps running after a disconnect
    send_event(lkrm_pkg::KIND_CONNECT, 16'd0);
    send_event(lkrm_pkg::KIND_DISCONNECT, 16'd0);
    send_event(lkrm_pkg::KIND_TICK, 16'd1000);
    send_event(lkrm_pkg::KIND_DISCONNECT, 16'd0);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: vals = '{8'd1, 8'd1, 8'd1, 8'd1};
        1: vals = '{8'd255, 8'd255, 8'd255, 8'd255};
        2: vals = '{8'd2, 8'd5, 8'd8, 8'd1};
        3: foreach (vals[i]) vals[i] = 8'($urandom_range(1, 255));
        default: vals = '{8'd1, 8'd255, 8'd3, 8'd255};
      endcase
      drain_and_configure(vals);
      idle_mode = p % 4;
      if (p == PHASES - 1) hold_request = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        sender_gap();
        send_event(random_kind(), random_ms());
      end
    end

    in_valid <= 1'b0;
    while (sb.link_words_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    $display("summary: %0d events through all link states under %0d register settings,",
             sb.events_noted, settings_used);
    $display("summary: %0d result words compared, %0d mismatches",
             sb.words_checked, sb.errors);
    if (sb.errors == 0)
      $display("link_keepalive_reconnect_manager_tb: clean");
    else
      $display("link_keepalive_reconnect_manager_tb: errors");
    $finish;
  end

endmodule

/* link_keepalive_reconnect_manager.f */
hw/rtl/lkrm_pkg.sv
hw/rtl/lkrm_timer.sv
hw/rtl/link_keepalive_reconnect_manager.sv
dv/lkrm_tb_pkg.sv
dv/link_keepalive_reconnect_manager_tb.sv
